### rtl/core/rdq_pkg.sv
// Package for the reversible deque: store size, pointer widths,
// operation and status codes shared by the interfaces and the modules.
// No dependencies.
package rdq_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int SUM_W = OCC_W + 1;
	localparam int DW    = 32;

	typedef enum logic [2:0] {
		OP_POP_BACK   = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_REVERSE    = 3'd2,
		OP_PUSH_BACK  = 3'd3,
		OP_PUSH_FRONT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef logic [AW-1:0]    addr_t;
	typedef logic [OCC_W-1:0] occ_t;

endpackage

### rtl/core/rdq_if.sv
// Handshake channels of the reversible deque: operation beats in,
// result beats out. Depends on rdq_pkg.
interface rdq_op_if import rdq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface rdq_res_if import rdq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] popped;

	modport source (output valid, output status, output popped, input ready);
	modport sink   (input valid, input status, input popped, output ready);
endinterface

### rtl/core/reversible_deque.sv
// Reversible double-ended queue of 32-bit values held in one RAM.
// Depends on rdq_pkg, rdq_op_if / rdq_res_if and rdq_ram.
//
// Usage:
//  - req carries one operation per beat: pop back, pop front, reverse,
//    push back, push front (codes in rdq_pkg); value matters for pushes only.
//  - rsp returns exactly one result beat per request beat, in order:
//    status (done, popped, empty, full) and the popped value (zero unless
//    a value was popped).
//  - Pushes, reverse and every empty/full/no-op case load the result
//    register at the request beat, so the result is registered the cycle
//    after the beat and the next request can be taken in that same cycle.
//    A successful pop reads the RAM (registered read), then the result
//    register loads the data; req is held off while the read is outstanding.
//  - Sustained rate: one beat per cycle for pushes while rsp does not stall;
//    each pop holds off req while its read on the single RAM port is outstanding.
//  - Reset clears head pointer, occupancy, reversed flag, pend_q and the result
//    valid bit; status, data and RAM are not cleared; only occupied entries are ever read.
//  - When rsp stalls, the result register holds and req is taken only as
//    that register drains, so nothing is lost or repeated.
module reversible_deque import rdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rdq_op_if.sink     req,
	rdq_res_if.source  rsp
);

	// Queue state
	addr_t head_q;
	occ_t  occ_q;
	logic  rev_q;

	// Pop read outstanding
	logic pend_q;

	// Result register
	logic           rsp_valid_q;
	status_t        rsp_status_q;
	logic [DW-1:0]  rsp_popped_q;

	// RAM port
	logic           ram_en;
	logic           ram_we;
	addr_t          ram_addr;
	logic [DW-1:0]  ram_rdata;

	logic accept;
	logic empty;
	logic full;
	logic to_phys_back;
	addr_t head_inc;
	addr_t head_dec;
	addr_t tail_addr;
	addr_t last_addr;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_m1;

	// Accept only with no read in flight and the result slot free or draining
	assign req.ready = !pend_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign empty = (occ_q == '0);
	assign full  = (occ_q == OCC_W'(DEPTH));

	// Wrapped pointers: head plus occupancy stays below twice the depth
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign sum      = SUM_W'(head_q) + SUM_W'(occ_q);
	assign sum_m1   = sum - SUM_W'(1);
	assign tail_addr = (sum >= SUM_W'(DEPTH)) ? AW'(sum - SUM_W'(DEPTH)) : AW'(sum);
	assign last_addr = (sum_m1 >= SUM_W'(DEPTH)) ? AW'(sum_m1 - SUM_W'(DEPTH))
		: AW'(sum_m1);

	// Logical back maps to the physical back in normal order
	always_comb begin
		case (req.operation)
			OP_POP_BACK, OP_PUSH_BACK: to_phys_back = !rev_q;
			default:                   to_phys_back = rev_q;
		endcase
	end

	// RAM access for the accepted beat
	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = head_q;
		case (req.operation)
			OP_POP_BACK, OP_POP_FRONT: begin
				ram_en   = accept && !empty;
				ram_addr = to_phys_back ? last_addr : head_q;
			end
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				ram_en   = accept && !full;
				ram_we   = 1'b1;
				ram_addr = to_phys_back ? tail_addr : head_dec;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	rdq_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.value),
		.rdata (ram_rdata)
	);

	// Pointer and flag update at the request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			rev_q  <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			if (accept) begin
				case (req.operation)
					OP_POP_BACK, OP_POP_FRONT: begin
						if (!empty) begin
							occ_q  <= occ_q - OCC_W'(1);
							pend_q <= 1'b1;
							if (!to_phys_back) begin
								head_q <= head_inc;
							end
						end
					end
					OP_REVERSE: begin
						if (!empty) begin
							rev_q <= !rev_q;
						end
					end
					OP_PUSH_BACK, OP_PUSH_FRONT: begin
						if (!full) begin
							occ_q <= occ_q + OCC_W'(1);
							if (!to_phys_back) begin
								head_q <= head_dec;
							end
						end
					end
					default: begin
						head_q <= head_q;
					end
				endcase
			end
		end
	end

	// Result register: load read data after a pop, otherwise at the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pend_q) begin
			rsp_valid_q <= 1'b1;
		end else if (accept) begin
			case (req.operation)
				OP_POP_BACK, OP_POP_FRONT: rsp_valid_q <= empty;
				default:                   rsp_valid_q <= 1'b1;
			endcase
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			rsp_status_q <= ST_POPPED;
			rsp_popped_q <= ram_rdata;
		end else if (accept) begin
			rsp_popped_q <= '0;
			case (req.operation)
				OP_POP_BACK, OP_POP_FRONT: rsp_status_q <= ST_EMPTY;
				OP_PUSH_BACK, OP_PUSH_FRONT: rsp_status_q <= full ? ST_FULL : ST_DONE;
				default:                   rsp_status_q <= ST_DONE;
			endcase
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.popped = rsp_popped_q;

	// Checks
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy beyond depth");

	a_pend_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !rsp_valid_q)
		else $error("result slot busy while a pop read is outstanding");

	a_pend_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(accept) && $past(!empty) &&
			($past(req.operation) == OP_POP_BACK || $past(req.operation) == OP_POP_FRONT))
		else $error("read outstanding without a pop");

	a_rev_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && req.operation == OP_REVERSE) |=> $stable(rev_q))
		else $error("reversed flag changed without a reverse");

endmodule

### rtl/core/rdq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
